@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the buzzer tone sequencer checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define BTS_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define BTS_ASSERT_ANY(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

@@ src/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// bts_pkg
// types and constants of the buzzer tone sequencer
// ----------------------------------------------------------------------------
package bts_pkg;

	// field widths of the beats
	localparam int KIND_W = 2;
	localparam int EL_W   = 16;
	localparam int ADDR_W = 5;
	localparam int FREQ_W = 16;
	localparam int DUR_W  = 15;
	localparam int REST_W = 16;
	localparam int TONE_W = 16;

	// beat kinds; the fourth code is ignored
	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_START = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	// one note entry
	typedef struct packed {
		logic        [FREQ_W-1:0] freq;
		logic        [DUR_W-1:0]  dur;
		logic signed [REST_W-1:0] rest;
	} note_t;

	// tone word: on bit plus frequency scaled by 21990/65536
	localparam logic [14:0]       TONE_SCALE = 15'd21990;
	localparam logic [TONE_W-1:0] TONE_ON    = 16'h8000;
	localparam logic [TONE_W-1:0] TONE_OFF   = 16'h0000;

endpackage

@@ src/bts_if.sv @@
// ----------------------------------------------------------------------------
// bts_if
// valid/ready channels of the buzzer tone sequencer
// ----------------------------------------------------------------------------

// request beats: tick, start or note write
interface bts_in_if;
	logic                            valid;
	logic                            ready;
	logic [bts_pkg::KIND_W-1:0]      kind;
	logic [bts_pkg::EL_W-1:0]        elapsed;
	logic                            program_present;
	logic [bts_pkg::ADDR_W-1:0]      note_address;
	logic [bts_pkg::FREQ_W-1:0]      note_frequency;
	logic [bts_pkg::DUR_W-1:0]       note_duration;
	logic signed [bts_pkg::REST_W-1:0] note_rest;

	modport source (
		output valid, kind, elapsed, program_present, note_address,
		       note_frequency, note_duration, note_rest,
		input  ready
	);
	modport sink (
		input  valid, kind, elapsed, program_present, note_address,
		       note_frequency, note_duration, note_rest,
		output ready
	);
endinterface

// result beats: buzzer tone word writes
interface bts_out_if;
	logic                       valid;
	logic                       ready;
	logic [bts_pkg::TONE_W-1:0] tone_word;
	logic                       playing;

	modport source (output valid, tone_word, playing, input ready);
	modport sink (input valid, tone_word, playing, output ready);
endinterface

@@ src/bts_ram.sv @@
// ----------------------------------------------------------------------------
// bts_ram
// generic single write, single read RAM with registered read (read-first)
// ----------------------------------------------------------------------------
module bts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/buzzer_tone_sequencer.sv @@
// ----------------------------------------------------------------------------
// buzzer_tone_sequencer
// plays tone programs from a note RAM and writes buzzer tone words
// ----------------------------------------------------------------------------
//  channel    dir  handshake            payload
//  note_in    in   valid/ready          kind, elapsed, program_present,
//                                       note_address, note_frequency,
//                                       note_duration, note_rest
//  tone_out   out  valid/ready          tone_word, playing
//  cfg        in   cfg_we (no stall)    cfg_wdata = mute
//
//  A beat enters a stage register while the note RAM read for its address
//  runs; from there, unless a stall holds it, it updates the player state and
//  the result register, from which its result leaves when taken.
//  One beat per cycle unless stalled; a beat that starts a note holds off the next,
//  as the single RAM read port then fetches the note that follows into a local copy.
//  Reset clears the player and pending slot; the note RAM is not cleared.
//  A full, stalled result register holds back only beats that give a result.
// ----------------------------------------------------------------------------
module buzzer_tone_sequencer #(
	parameter int NOTE_DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	bts_in_if.sink          note_in,
	bts_out_if.source       tone_out
);

	localparam int IDX_W  = $clog2(NOTE_DEPTH);
	localparam int WRAP_W = (IDX_W >= bts_pkg::ADDR_W) ? IDX_W + 1 : bts_pkg::ADDR_W + 1;

	typedef logic [IDX_W-1:0] idx_t;

	// address modulo depth by repeated subtract (at most seven steps at depth 4)
	function automatic idx_t wrap_in(input logic [bts_pkg::ADDR_W-1:0] a);
		logic [WRAP_W-1:0] v;
		v = WRAP_W'(a);
		for (int i = 0; i < 8; i++) begin
			if (v >= WRAP_W'(NOTE_DEPTH)) begin
				v = v - WRAP_W'(NOTE_DEPTH);
			end
		end
		return v[IDX_W-1:0];
	endfunction

	// following note address with wrap
	function automatic idx_t nxt_of(input idx_t a);
		return (a == IDX_W'(NOTE_DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	// input side
	logic           in_acc;
	idx_t           in_addr;
	bts_pkg::note_t in_entry;

	// stage register
	logic                        valid_s1;
	logic [bts_pkg::KIND_W-1:0]  kind_s1;
	logic [bts_pkg::EL_W-1:0]    elapsed_s1;
	logic                        present_s1;
	idx_t                        addr_s1;
	bts_pkg::note_t              entry_s1;

	// player state
	logic                        mute_q;
	logic                        active_q, active_d;
	idx_t                        cur_q, cur_d;
	logic signed [16:0]          time_q, time_d;
	logic                        pv_q, pv_d;
	logic                        ppres_q, ppres_d;
	idx_t                        paddr_q, paddr_d;
	logic signed [bts_pkg::REST_W-1:0] cur_rest_q, cur_rest_d;
	idx_t                        nxt_addr_q, nxt_addr_d;
	bts_pkg::note_t              nxt_q, nxt_d;
	bts_pkg::note_t              pnd_q, pnd_d;
	logic                        refill_q;

	// result register
	logic                        out_valid_q;
	logic [bts_pkg::TONE_W-1:0]  out_tone_q;
	logic                        out_play_q;

	// RAM
	logic                              ram_we;
	idx_t                              ram_raddr;
	logic [$bits(bts_pkg::note_t)-1:0] ram_rdata;
	bts_pkg::note_t                    rd_entry;

	// step logic
	logic                        res;
	logic                        beg;
	logic                        tone_on;
	bts_pkg::note_t              beg_entry;
	idx_t                        beg_addr;
	logic signed [17:0]          dn;
	logic signed [17:0]          dp;
	logic [30:0]                 prod;
	logic [bts_pkg::TONE_W-1:0]  tone;
	logic                        s1_stall;
	logic                        refill_go;

	assign in_acc         = note_in.valid && note_in.ready;
	assign in_addr        = wrap_in(note_in.note_address);
	assign in_entry.freq  = note_in.note_frequency;
	assign in_entry.dur   = note_in.note_duration;
	assign in_entry.rest  = note_in.note_rest;
	assign rd_entry       = bts_pkg::note_t'(ram_rdata);

	// note writes go straight to the RAM when the beat is taken
	assign ram_we = in_acc && (note_in.kind == bts_pkg::KIND_WRITE);

	bts_ram #(
		.WIDTH ($bits(bts_pkg::note_t)),
		.DEPTH (NOTE_DEPTH)
	) u_note_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_addr),
		.wdata (in_entry),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// time arithmetic for the running note or rest
	assign dn = $signed({time_q[16], time_q}) - $signed({2'b00, elapsed_s1});
	assign dp = $signed({time_q[16], time_q}) + $signed({2'b00, elapsed_s1});

	// next player state for the beat in the stage register
	always_comb begin
		active_d   = active_q;
		cur_d      = cur_q;
		time_d     = time_q;
		pv_d       = pv_q;
		ppres_d    = ppres_q;
		paddr_d    = paddr_q;
		cur_rest_d = cur_rest_q;
		nxt_addr_d = nxt_addr_q;
		nxt_d      = refill_q ? rd_entry : nxt_q;
		pnd_d      = pnd_q;
		res        = 1'b0;
		beg        = 1'b0;
		beg_entry  = rd_entry;
		beg_addr   = addr_s1;
		if (valid_s1) begin
			if (kind_s1 == bts_pkg::KIND_WRITE) begin
				// keep local copies in step with the RAM
				if (addr_s1 == cur_q) begin
					cur_rest_d = entry_s1.rest;
				end
				if (addr_s1 == nxt_addr_q) begin
					nxt_d = entry_s1;
				end
				if (addr_s1 == paddr_q) begin
					pnd_d = entry_s1;
				end
			end else if (kind_s1 == bts_pkg::KIND_START && !mute_q) begin
				if (!active_q) begin
					res = 1'b1;
					beg = present_s1;
				end else begin
					pv_d    = 1'b1;
					ppres_d = present_s1;
					paddr_d = addr_s1;
					pnd_d   = rd_entry;
				end
			end else if (kind_s1 == bts_pkg::KIND_TICK && !mute_q && active_q
					&& elapsed_s1 != '0) begin
				if (!time_q[16]) begin
					if (!dn[17] && dn != '0) begin
						time_d = dn[16:0];
					end else if (cur_rest_q[15]) begin
						// program end: start the pending request, if any
						res       = 1'b1;
						beg       = pv_q && ppres_q;
						beg_entry = pnd_q;
						beg_addr  = paddr_q;
						active_d  = 1'b0;
						pv_d      = 1'b0;
						ppres_d   = 1'b0;
						paddr_d   = '0;
					end else if (cur_rest_q == '0) begin
						res       = 1'b1;
						beg       = 1'b1;
						beg_entry = nxt_q;
						beg_addr  = nxt_addr_q;
					end else begin
						res    = 1'b1;
						time_d = -$signed({cur_rest_q[15], cur_rest_q});
					end
				end else if (dp[17]) begin
					time_d = dp[16:0];
				end else begin
					res       = 1'b1;
					beg       = 1'b1;
					beg_entry = nxt_q;
					beg_addr  = nxt_addr_q;
				end
			end else begin
				// ignored beat
				res = 1'b0;
			end
		end
		// a silence start leaves the block idle
		if (res && !beg && kind_s1 == bts_pkg::KIND_START) begin
			active_d = 1'b0;
		end
		if (beg) begin
			active_d   = 1'b1;
			cur_d      = beg_addr;
			time_d     = {2'b00, beg_entry.dur};
			cur_rest_d = beg_entry.rest;
			nxt_addr_d = nxt_of(beg_addr);
		end
		tone_on = beg;
	end

	// tone word of the note that starts
	assign prod = 31'(beg_entry.freq) * 31'(bts_pkg::TONE_SCALE);
	assign tone = tone_on ? (bts_pkg::TONE_ON | {1'b0, prod[30:16]}) : bts_pkg::TONE_OFF;

	// flow control and RAM read address
	assign s1_stall  = valid_s1 && res && out_valid_q && !tone_out.ready;
	assign refill_go = valid_s1 && !s1_stall && beg;
	assign note_in.ready = !s1_stall && !refill_go;

	always_comb begin
		if (refill_go) begin
			ram_raddr = nxt_addr_d;
		end else if (s1_stall) begin
			ram_raddr = addr_s1;
		end else begin
			ram_raddr = in_addr;
		end
	end

	// mute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q <= 1'b0;
		end else if (cfg_we) begin
			mute_q <= cfg_wdata;
		end
	end

	// stage register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			refill_q <= 1'b0;
		end else begin
			refill_q <= refill_go;
			if (!s1_stall) begin
				valid_s1 <= in_acc;
			end
		end
	end

	// stage register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1    <= note_in.kind;
			elapsed_s1 <= note_in.elapsed;
			present_s1 <= note_in.program_present;
			addr_s1    <= in_addr;
			entry_s1   <= in_entry;
		end
	end

	// player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			cur_q      <= '0;
			time_q     <= '0;
			pv_q       <= 1'b0;
			ppres_q    <= 1'b0;
			paddr_q    <= '0;
			nxt_addr_q <= '0;
		end else if (!s1_stall) begin
			active_q   <= active_d;
			cur_q      <= cur_d;
			time_q     <= time_d;
			pv_q       <= pv_d;
			ppres_q    <= ppres_d;
			paddr_q    <= paddr_d;
			nxt_addr_q <= nxt_addr_d;
		end
	end

	// local note copies
	always_ff @(posedge clk) begin
		if (!s1_stall) begin
			cur_rest_q <= cur_rest_d;
			nxt_q      <= nxt_d;
			pnd_q      <= pnd_d;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && !s1_stall && res) begin
			out_valid_q <= 1'b1;
		end else if (tone_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (valid_s1 && !s1_stall && res) begin
			out_tone_q <= tone;
			out_play_q <= active_d;
		end
	end

	assign tone_out.valid     = out_valid_q;
	assign tone_out.tone_word = out_tone_q;
	assign tone_out.playing   = out_play_q;

endmodule

@@ src/bts_checker.sv @@
// ----------------------------------------------------------------------------
// bts_checker
// port-level checks of the buzzer tone sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bts_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [bts_pkg::TONE_W-1:0] out_tone,
	input logic                       out_playing
);

	// a stalled result beat holds
	`BTS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_tone) && $stable(out_playing), "result beat changed while stalled")

	// a fresh result must follow an accepted input beat
	`BTS_ASSERT(a_out_latency, clk, arst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without input beat two cycles before")

	// an idle player writes silence
	`BTS_ASSERT(a_idle_silent, clk, arst_n, out_valid && !out_playing |-> out_tone == bts_pkg::TONE_OFF, "tone written while not playing")

	// no result during reset
	`BTS_ASSERT_ANY(a_rst_quiet, clk, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind buzzer_tone_sequencer bts_checker u_bts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (note_in.valid),
	.in_ready    (note_in.ready),
	.out_valid   (tone_out.valid),
	.out_ready   (tone_out.ready),
	.out_tone    (tone_out.tone_word),
	.out_playing (tone_out.playing)
);
